// ----- design/chacha20_block_function_macros.svh -----
`ifndef CHACHA20_BLOCK_FUNCTION_MACROS_SVH
`define CHACHA20_BLOCK_FUNCTION_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CHACHA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("chacha block function check failed");

// next-cycle implication, sampled on aclk, off during reset
`define CHACHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("chacha block function check failed");

`endif

// ----- design/chacha_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package chacha_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int STAGES        = 4 * DOUBLE_ROUNDS;

    typedef logic [31:0]       word_t;
    typedef logic [15:0][31:0] state_t;

    // rotate row r left by r lanes: diagonals become columns
    function automatic state_t rows_rotate(input state_t x);
        state_t y;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                y[r * 4 + c] = x[r * 4 + ((c + r) & 3)];
            end
        end
        return y;
    endfunction

    // undo rows_rotate
    function automatic state_t rows_unrotate(input state_t x);
        state_t y;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                y[r * 4 + ((c + r) & 3)] = x[r * 4 + c];
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- design/chacha_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module chacha_cell
    import chacha_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   advance,
    input  wire logic   half_sel,
    input  wire logic   in_valid,
    input  wire state_t in_work,
    input  wire state_t in_init,
    output logic        out_valid,
    output state_t      out_work,
    output state_t      out_init
);

    logic   valid_reg;
    state_t work_reg;
    state_t init_reg;
    state_t work_next;

    // half of a column quarterround on all four columns
    always_comb begin
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t t;
        for (int col = 0; col < 4; col++) begin
            a = in_work[col];
            b = in_work[4 + col];
            c = in_work[8 + col];
            d = in_work[12 + col];
            a = a + b;
            t = d ^ a;
            d = half_sel ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
            c = c + d;
            t = b ^ c;
            b = half_sel ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
            work_next[col]      = a;
            work_next[4 + col]  = b;
            work_next[8 + col]  = c;
            work_next[12 + col] = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            work_reg <= work_next;
            init_reg <= in_init;
        end
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;
    assign out_init  = init_reg;

endmodule

`default_nettype wire

// ----- design/chacha20_block_function.sv -----
`timescale 1ns / 1ps
`default_nettype none

// ChaCha block function: takes one 16-word state a request and returns the
// keystream block (ten double rounds, then the input added word-wise mod 2^32).
// Words travel in pairs, even word in bits 31..0 and odd word in bits 63..32.
// A chain of 40 cells, each doing half of a quarterround on all four columns
// (two dependent 32-bit adds), plus the output register that does the final
// add, gives a rate of one block per cycle. The whole chain holds while a
// result waits on m_ready. Diagonal rounds are formed by rotating rows
// between cells.

`include "chacha20_block_function_macros.svh"

module chacha20_block_function
    import chacha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_in_words_0_1,
    input  wire logic [63:0] s_in_words_2_3,
    input  wire logic [63:0] s_in_words_4_5,
    input  wire logic [63:0] s_in_words_6_7,
    input  wire logic [63:0] s_in_words_8_9,
    input  wire logic [63:0] s_in_words_10_11,
    input  wire logic [63:0] s_in_words_12_13,
    input  wire logic [63:0] s_in_words_14_15,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_words_0_1,
    output logic [63:0]      m_out_words_2_3,
    output logic [63:0]      m_out_words_4_5,
    output logic [63:0]      m_out_words_6_7,
    output logic [63:0]      m_out_words_8_9,
    output logic [63:0]      m_out_words_10_11,
    output logic [63:0]      m_out_words_12_13,
    output logic [63:0]      m_out_words_14_15
);

    logic              advance;
    logic [STAGES:0]   stage_valid;
    state_t            stage_work [0:STAGES];
    state_t            stage_init [0:STAGES];
    state_t            req_state;
    state_t            final_work;
    state_t            sum_next;
    state_t            sum_reg;
    logic              m_valid_reg;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    assign req_state[0]  = s_in_words_0_1[31:0];
    assign req_state[1]  = s_in_words_0_1[63:32];
    assign req_state[2]  = s_in_words_2_3[31:0];
    assign req_state[3]  = s_in_words_2_3[63:32];
    assign req_state[4]  = s_in_words_4_5[31:0];
    assign req_state[5]  = s_in_words_4_5[63:32];
    assign req_state[6]  = s_in_words_6_7[31:0];
    assign req_state[7]  = s_in_words_6_7[63:32];
    assign req_state[8]  = s_in_words_8_9[31:0];
    assign req_state[9]  = s_in_words_8_9[63:32];
    assign req_state[10] = s_in_words_10_11[31:0];
    assign req_state[11] = s_in_words_10_11[63:32];
    assign req_state[12] = s_in_words_12_13[31:0];
    assign req_state[13] = s_in_words_12_13[63:32];
    assign req_state[14] = s_in_words_14_15[31:0];
    assign req_state[15] = s_in_words_14_15[63:32];

    assign stage_valid[0] = s_valid;
    assign stage_work[0]  = req_state;
    assign stage_init[0]  = req_state;

    for (genvar s = 0; s < STAGES; s++) begin : g_cell
        state_t cell_in;
        if (s % 4 == 2) begin : g_rot
            assign cell_in = rows_rotate(stage_work[s]);
        end else if (s % 4 == 0 && s > 0) begin : g_unrot
            assign cell_in = rows_unrotate(stage_work[s]);
        end else begin : g_pass
            assign cell_in = stage_work[s];
        end

        chacha_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .half_sel  ((s % 2 == 1) ? 1'b1 : 1'b0),
            .in_valid  (stage_valid[s]),
            .in_work   (cell_in),
            .in_init   (stage_init[s]),
            .out_valid (stage_valid[s + 1]),
            .out_work  (stage_work[s + 1]),
            .out_init  (stage_init[s + 1])
        );
    end

    assign final_work = rows_unrotate(stage_work[STAGES]);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sum_next[i] = final_work[i] + stage_init[STAGES][i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= stage_valid[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sum_reg <= sum_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_out_words_0_1   = {sum_reg[1],  sum_reg[0]};
    assign m_out_words_2_3   = {sum_reg[3],  sum_reg[2]};
    assign m_out_words_4_5   = {sum_reg[5],  sum_reg[4]};
    assign m_out_words_6_7   = {sum_reg[7],  sum_reg[6]};
    assign m_out_words_8_9   = {sum_reg[9],  sum_reg[8]};
    assign m_out_words_10_11 = {sum_reg[11], sum_reg[10]};
    assign m_out_words_12_13 = {sum_reg[13], sum_reg[12]};
    assign m_out_words_14_15 = {sum_reg[15], sum_reg[14]};

    `CHACHA_ASSERT_NEXT(a_enter_chain, s_valid && s_ready, stage_valid[1])
    `CHACHA_ASSERT_NEXT(a_leave_chain, stage_valid[STAGES] && advance, m_valid)
    `CHACHA_ASSERT_NEXT(a_chain_holds, !advance, $stable(stage_valid[STAGES:1]))
    `CHACHA_ASSERT_SAME(a_hold_when_full, m_valid && !m_ready, !s_ready)

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import chacha_pkg::*;

    typedef logic [7:0][63:0] block_t;

    localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
    localparam int RANDOM_BLOCKS = 1250;
    localparam int CALM_TAIL     = 200;
    localparam int PIPE_LATENCY  = 41;

    class keystream_board;
        block_t keystream_q[$];
        int     errors = 0;

        function word_t rotl(word_t v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function state_t quarter_mix(state_t x, int a, int b, int c, int d);
            x[a] = x[a] + x[b];
            x[d] = rotl(x[d] ^ x[a], 16);
            x[c] = x[c] + x[d];
            x[b] = rotl(x[b] ^ x[c], 12);
            x[a] = x[a] + x[b];
            x[d] = rotl(x[d] ^ x[a], 8);
            x[c] = x[c] + x[d];
            x[b] = rotl(x[b] ^ x[c], 7);
            return x;
        endfunction

        function block_t chacha_keystream(block_t blk);
            state_t init_w;
            state_t w;
            block_t res;
            for (int k = 0; k < 8; k++) begin
                init_w[2 * k]     = blk[k][31:0];
                init_w[2 * k + 1] = blk[k][63:32];
            end
            w = init_w;
            for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
                w = quarter_mix(w, 0, 4, 8, 12);
                w = quarter_mix(w, 1, 5, 9, 13);
                w = quarter_mix(w, 2, 6, 10, 14);
                w = quarter_mix(w, 3, 7, 11, 15);
                w = quarter_mix(w, 0, 5, 10, 15);
                w = quarter_mix(w, 1, 6, 11, 12);
                w = quarter_mix(w, 2, 7, 8, 13);
                w = quarter_mix(w, 3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) begin
                w[i] = w[i] + init_w[i];
            end
            for (int k = 0; k < 8; k++) begin
                res[k] = {w[2 * k + 1], w[2 * k]};
            end
            return res;
        endfunction

        function void note_request(block_t blk);
            keystream_q.push_back(chacha_keystream(blk));
        endfunction

        function void check_result(block_t got);
            block_t exp_blk;
            if (keystream_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                errors++;
                return;
            end
            exp_blk = keystream_q.pop_front();
            for (int k = 0; k < 8; k++) begin
                if (got[k] !== exp_blk[k]) begin
                    $display("%0t: out_words_%0d_%0d expected %h got %h",
                             $time, 2 * k, 2 * k + 1, exp_blk[k], got[k]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return keystream_q.size();
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_in_words_0_1   = '0;
    logic [63:0] s_in_words_2_3   = '0;
    logic [63:0] s_in_words_4_5   = '0;
    logic [63:0] s_in_words_6_7   = '0;
    logic [63:0] s_in_words_8_9   = '0;
    logic [63:0] s_in_words_10_11 = '0;
    logic [63:0] s_in_words_12_13 = '0;
    logic [63:0] s_in_words_14_15 = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_out_words_0_1;
    logic [63:0] m_out_words_2_3;
    logic [63:0] m_out_words_4_5;
    logic [63:0] m_out_words_6_7;
    logic [63:0] m_out_words_8_9;
    logic [63:0] m_out_words_10_11;
    logic [63:0] m_out_words_12_13;
    logic [63:0] m_out_words_14_15;

    keystream_board board = new();
    bit calm = 1'b0;
    int stall_left = 0;

    chacha20_block_function dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_words_0_1    (s_in_words_0_1),
        .s_in_words_2_3    (s_in_words_2_3),
        .s_in_words_4_5    (s_in_words_4_5),
        .s_in_words_6_7    (s_in_words_6_7),
        .s_in_words_8_9    (s_in_words_8_9),
        .s_in_words_10_11  (s_in_words_10_11),
        .s_in_words_12_13  (s_in_words_12_13),
        .s_in_words_14_15  (s_in_words_14_15),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_words_0_1   (m_out_words_0_1),
        .m_out_words_2_3   (m_out_words_2_3),
        .m_out_words_4_5   (m_out_words_4_5),
        .m_out_words_6_7   (m_out_words_6_7),
        .m_out_words_8_9   (m_out_words_8_9),
        .m_out_words_10_11 (m_out_words_10_11),
        .m_out_words_12_13 (m_out_words_12_13),
        .m_out_words_14_15 (m_out_words_14_15)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // check accepted results, then pick the next m_ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({m_out_words_14_15, m_out_words_12_13, m_out_words_10_11,
                                m_out_words_8_9, m_out_words_6_7, m_out_words_4_5,
                                m_out_words_2_3, m_out_words_0_1});
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0 && !calm) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_ready    <= 1'b0;
        end else begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end
    end

    function automatic block_t pack_words(state_t w);
        block_t blk;
        for (int k = 0; k < 8; k++) begin
            blk[k] = {w[2 * k + 1], w[2 * k]};
        end
        return blk;
    endfunction

    function automatic block_t random_state();
        state_t w;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 16; i++) begin
            w[i] = $urandom;
        end
        if (mode <= 4) begin
            w[3:0] = SIGMA;
        end else if (mode == 8) begin
            for (int i = 0; i < 16; i++) begin
                w[i] = $urandom & $urandom & $urandom;
            end
        end else if (mode == 9) begin
            for (int i = 0; i < 16; i++) begin
                w[i] = $urandom | $urandom | $urandom;
            end
        end
        return pack_words(w);
    endfunction

    // call right after a rising edge; returns at acceptance or after an idle gap
    task automatic send_block(input block_t blk);
        s_valid          <= 1'b1;
        s_in_words_0_1   <= blk[0];
        s_in_words_2_3   <= blk[1];
        s_in_words_4_5   <= blk[2];
        s_in_words_6_7   <= blk[3];
        s_in_words_8_9   <= blk[4];
        s_in_words_10_11 <= blk[5];
        s_in_words_12_13 <= blk[6];
        s_in_words_14_15 <= blk[7];
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.note_request(blk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        block_t blk;
        state_t w;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_block('0);
        send_block('1);
        for (int k = 0; k < 8; k++) begin
            blk    = '0;
            blk[k] = '1;
            send_block(blk);
        end
        send_block({8{64'h5555_5555_5555_5555}});
        send_block({8{64'hAAAA_AAAA_AAAA_AAAA}});
        w      = '0;
        w[3:0] = SIGMA;
        send_block(pack_words(w));
        w = {32'h00000000, 32'h4a000000, 32'h09000000, 32'h00000001,
             32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110,
             32'h0f0e0d0c, 32'h0b0a0908, 32'h07060504, 32'h03020100,
             32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
        send_block(pack_words(w));
        w      = '1;
        w[3:0] = SIGMA;
        send_block(pack_words(w));
        send_block(pack_words({16{32'h8000_0000}}));
        send_block(pack_words({16{32'h0000_0001}}));
        drain();

        for (int n = 0; n < RANDOM_BLOCKS; n++) begin
            if (n == RANDOM_BLOCKS - CALM_TAIL) begin
                calm = 1'b1;
            end
            if (n == 400 || n == 800) begin
                drain();
            end
            send_block(random_state());
        end
        drain();
        repeat (PIPE_LATENCY + 20) @(posedge aclk);

        if (board.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
